// File: rtl/core/temperature_step_profile_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the temperature step profile sequencer
// Concurrent checks clocked on clk_i with reset rst_ni; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_STEP_PROFILE_SEQUENCER_MACROS_SVH
`define TEMPERATURE_STEP_PROFILE_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define TSPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TSPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TSPS_ASSERT(lbl, prop, msg)
`define TSPS_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/tsps_pkg.sv
// ----------------------------------------------------------------------------
// tsps_pkg
// Types and constants shared by the temperature step profile sequencer.
// ----------------------------------------------------------------------------
package tsps_pkg;

  localparam int MaxSteps = 8;
  localparam int StepAw   = (MaxSteps > 1) ? $clog2(MaxSteps) : 1;
  localparam int TempW    = 12;
  localparam int MinW     = 10;
  localparam int PtrW     = 4;
  localparam int TimeW    = 16;
  localparam int TolW     = 8;
  localparam int IdxW     = 3;
  localparam int OpW      = 3;
  localparam int CmpW     = TempW + 2;
  localparam int EntryW   = TempW + MinW;
  localparam int SecPerMin = 60;

  localparam logic [PtrW-1:0]         StepCountRst = 4'd0;
  localparam logic [TimeW-1:0]        CoolDownRst  = 16'd600;
  localparam logic [TolW-1:0]         ToleranceRst = 8'd8;
  localparam logic signed [TempW-1:0] IdleRst      = 12'sd320;
  localparam logic signed [TempW-1:0] TargetRst    = 12'sd320;

  typedef enum logic [OpW-1:0] {
    OpTick   = 3'd0,
    OpLoad   = 3'd1,
    OpStart  = 3'd2,
    OpPause  = 3'd3,
    OpResume = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CfgStepCount  = 2'd0,
    CfgCoolDown   = 2'd1,
    CfgTolerance  = 2'd2,
    CfgIdleTarget = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [OpW-1:0]         opcode;
    logic signed [TempW-1:0] temperature;
    logic [IdxW-1:0]        entry_index;
    logic signed [TempW-1:0] entry_temp;
    logic [MinW-1:0]        entry_minutes;
  } item_t;

  typedef struct packed {
    logic [PtrW-1:0]         step_count;
    logic [TimeW-1:0]        cool_down_seconds;
    logic [TolW-1:0]         reach_tolerance;
    logic signed [TempW-1:0] idle_target;
  } cfg_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [MinW-1:0]         minutes;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [StepAw-1:0] addr;
    entry_t            data;
  } ram_wr_t;

  typedef struct packed {
    logic                    running;
    logic                    paused_flag;
    logic                    waiting_for_temp;
    logic                    cooling;
    logic [PtrW-1:0]         step_number;
    logic signed [TempW-1:0] target_temp;
    logic                    heater_force_off;
    logic                    mixer_auto;
    logic                    mixer_stop;
    logic                    hold_started;
    logic                    cool_down_done;
  } result_t;

endpackage

// File: rtl/core/tsps_ram.sv
// ----------------------------------------------------------------------------
// tsps_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsps_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/tsps_exec.sv
// ----------------------------------------------------------------------------
// tsps_exec
// Sequencer state and per-beat update: step entry, reach test, hold and
// cool-down timing, table write requests.
// ----------------------------------------------------------------------------
module tsps_exec (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  tsps_pkg::item_t           item_i,
  input  tsps_pkg::entry_t          entry_i,
  input  tsps_pkg::cfg_t            cfg_i,
  output logic [tsps_pkg::PtrW-1:0] ptr_next_o,
  output tsps_pkg::ram_wr_t         wr_o,
  output tsps_pkg::result_t         result_o
);

  logic [tsps_pkg::PtrW-1:0]         ptr_q, ptr_d;
  logic                              run_q, run_d;
  logic                              pause_q, pause_d;
  logic                              wait_q, wait_d;
  logic                              cool_q, cool_d;
  logic                              mix_auto_q, mix_auto_d;
  logic signed [tsps_pkg::TempW-1:0] target_q, target_d;
  logic [tsps_pkg::TimeW-1:0]        hold_el_q, hold_el_d;
  logic [tsps_pkg::TimeW-1:0]        hold_len_q, hold_len_d;
  logic [tsps_pkg::TimeW-1:0]        cool_el_q, cool_el_d;

  logic [tsps_pkg::PtrW-1:0]         eff_count;
  logic [tsps_pkg::PtrW-1:0]         enter_ptr;
  logic                              do_enter;
  logic [tsps_pkg::TimeW-1:0]        hold_inc, cool_inc, entry_len;
  logic signed [tsps_pkg::CmpW-1:0]  temp_ext, thresh;
  logic                              reached;
  logic                              p_heater, p_mstop, p_hold, p_cdone;
  tsps_pkg::op_e                     op;

  assign op        = tsps_pkg::op_e'(item_i.opcode);
  assign eff_count = (int'(cfg_i.step_count) > tsps_pkg::MaxSteps) ?
                     tsps_pkg::PtrW'(tsps_pkg::MaxSteps) : cfg_i.step_count;
  assign hold_inc  = (hold_el_q != '1) ? hold_el_q + 1'b1 : hold_el_q;
  assign cool_inc  = (cool_el_q != '1) ? cool_el_q + 1'b1 : cool_el_q;
  assign entry_len = tsps_pkg::TimeW'(32'(entry_i.minutes) * tsps_pkg::SecPerMin);
  assign temp_ext  = tsps_pkg::CmpW'(item_i.temperature);
  assign thresh    = tsps_pkg::CmpW'(target_q) -
                     signed'({{(tsps_pkg::CmpW - tsps_pkg::TolW){1'b0}}, cfg_i.reach_tolerance});
  assign reached   = (temp_ext >= thresh);

  always_comb begin
    ptr_d      = ptr_q;
    run_d      = run_q;
    pause_d    = pause_q;
    wait_d     = wait_q;
    cool_d     = cool_q;
    mix_auto_d = mix_auto_q;
    target_d   = target_q;
    hold_el_d  = hold_el_q;
    hold_len_d = hold_len_q;
    cool_el_d  = cool_el_q;
    p_heater   = 1'b0;
    p_mstop    = 1'b0;
    p_hold     = 1'b0;
    p_cdone    = 1'b0;
    do_enter   = 1'b0;
    enter_ptr  = ptr_q;
    wr_o       = '0;
    wr_o.addr  = tsps_pkg::StepAw'(item_i.entry_index);
    wr_o.data  = '{temp: item_i.entry_temp, minutes: item_i.entry_minutes};

    if (fire_i) begin
      case (op)
        tsps_pkg::OpTick: begin
          if (run_q) begin
            if (cool_q) begin
              cool_el_d = cool_inc;
              if (cool_inc >= cfg_i.cool_down_seconds) begin
                cool_d     = 1'b0;
                run_d      = 1'b0;
                pause_d    = 1'b0;
                mix_auto_d = 1'b0;
                p_mstop    = 1'b1;
                p_cdone    = 1'b1;
              end
            end else if (!pause_q) begin
              if (wait_q) begin
                if (reached) begin
                  wait_d    = 1'b0;
                  hold_el_d = '0;
                  p_hold    = 1'b1;
                end
              end else begin
                hold_el_d = hold_inc;
                if (hold_inc >= hold_len_q) begin
                  do_enter  = 1'b1;
                  enter_ptr = ptr_q + 1'b1;
                end
              end
            end
          end
        end
        tsps_pkg::OpLoad: begin
          wr_o.we = (int'(item_i.entry_index) < tsps_pkg::MaxSteps);
        end
        tsps_pkg::OpStart: begin
          run_d     = 1'b1;
          pause_d   = 1'b0;
          cool_d    = 1'b0;
          wait_d    = 1'b0;
          hold_el_d = '0;
          cool_el_d = '0;
          do_enter  = 1'b1;
          enter_ptr = '0;
        end
        tsps_pkg::OpPause: begin
          if (run_q) begin
            pause_d = 1'b1;
          end
        end
        tsps_pkg::OpResume: begin
          pause_d = 1'b0;
        end
        default: begin
        end
      endcase

      if (do_enter) begin
        ptr_d = enter_ptr;
        if (enter_ptr >= eff_count) begin
          p_heater   = 1'b1;
          target_d   = cfg_i.idle_target;
          mix_auto_d = 1'b1;
          p_mstop    = 1'b1;
          cool_d     = 1'b1;
          cool_el_d  = '0;
        end else begin
          target_d   = entry_i.temp;
          hold_len_d = entry_len;
          wait_d     = 1'b1;
          hold_el_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      run_q      <= 1'b0;
      pause_q    <= 1'b0;
      wait_q     <= 1'b0;
      cool_q     <= 1'b0;
      mix_auto_q <= 1'b0;
      target_q   <= tsps_pkg::TargetRst;
      hold_el_q  <= '0;
      hold_len_q <= '0;
      cool_el_q  <= '0;
    end else begin
      ptr_q      <= ptr_d;
      run_q      <= run_d;
      pause_q    <= pause_d;
      wait_q     <= wait_d;
      cool_q     <= cool_d;
      mix_auto_q <= mix_auto_d;
      target_q   <= target_d;
      hold_el_q  <= hold_el_d;
      hold_len_q <= hold_len_d;
      cool_el_q  <= cool_el_d;
    end
  end

  assign ptr_next_o = ptr_d;

  always_comb begin
    result_o.running          = run_d;
    result_o.paused_flag      = pause_d;
    result_o.waiting_for_temp = wait_d;
    result_o.cooling          = cool_d;
    result_o.step_number      = ptr_d;
    result_o.target_temp      = target_d;
    result_o.heater_force_off = p_heater;
    result_o.mixer_auto       = mix_auto_d;
    result_o.mixer_stop       = p_mstop;
    result_o.hold_started     = p_hold;
    result_o.cool_down_done   = p_cdone;
  end

endmodule

// File: rtl/core/temperature_step_profile_sequencer.sv
// ----------------------------------------------------------------------------
// temperature_step_profile_sequencer
// Ramp and soak sequencer over a step table held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o): one beat per command: tick with a
//   temperature sample, load step, start, pause or resume.
//   Output channel (out_valid_o / out_ready_i): one status beat per command,
//   showing the state after that command plus event pulses.
//   Config channel (cfg_valid_i / cfg_ready_o): always ready; write only while
//   no command is in flight.
//   Pipeline: an accepted command is held in the execute stage register, and
//   its status beat is registered in the output register when that stage fires.
//   The step table RAM is read when the command is accepted, with the address
//   taken from the sequencer state as it stands after the command ahead of it.
//   Throughput: one command per cycle while out_ready_i stays high.
//   Stall: when out_ready_i is low, the output register holds its beat and the
//   execute stage holds one more command; in_ready_o drops once both are full.
//   Reset: sequencer idle, step 0, target 320, registers at their defaults.
//   Table entries are undefined until loaded; no clearing pass is made.
// ----------------------------------------------------------------------------
`include "temperature_step_profile_sequencer_macros.svh"

module temperature_step_profile_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [15:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tsps_pkg::OpW-1:0]          opcode_i,
  input  logic signed [tsps_pkg::TempW-1:0] temperature_i,
  input  logic [tsps_pkg::IdxW-1:0]         entry_index_i,
  input  logic signed [tsps_pkg::TempW-1:0] entry_temp_i,
  input  logic [tsps_pkg::MinW-1:0]         entry_minutes_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              running_o,
  output logic                              paused_flag_o,
  output logic                              waiting_for_temp_o,
  output logic                              cooling_o,
  output logic [tsps_pkg::PtrW-1:0]         step_number_o,
  output logic signed [tsps_pkg::TempW-1:0] target_temp_o,
  output logic                              heater_force_off_o,
  output logic                              mixer_auto_o,
  output logic                              mixer_stop_o,
  output logic                              hold_started_o,
  output logic                              cool_down_done_o
);

  tsps_pkg::cfg_t    cfg_q;
  tsps_pkg::item_t   s1_item_q;
  logic              s1_valid_q;
  logic              s1_fire, in_fire;
  logic              out_valid_q;
  tsps_pkg::result_t out_q, result;
  tsps_pkg::ram_wr_t wr;
  tsps_pkg::entry_t  entry, ram_rdata, byp_data_q;
  logic              byp_q;
  logic [tsps_pkg::PtrW-1:0]   ptr_next, ptr_inc;
  logic [tsps_pkg::StepAw-1:0] raddr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_count        <= tsps_pkg::StepCountRst;
      cfg_q.cool_down_seconds <= tsps_pkg::CoolDownRst;
      cfg_q.reach_tolerance   <= tsps_pkg::ToleranceRst;
      cfg_q.idle_target       <= tsps_pkg::IdleRst;
    end else if (cfg_valid_i) begin
      unique case (tsps_pkg::cfg_reg_e'(cfg_index_i))
        tsps_pkg::CfgStepCount:  cfg_q.step_count        <= cfg_data_i[tsps_pkg::PtrW-1:0];
        tsps_pkg::CfgCoolDown:   cfg_q.cool_down_seconds <= cfg_data_i[tsps_pkg::TimeW-1:0];
        tsps_pkg::CfgTolerance:  cfg_q.reach_tolerance   <= cfg_data_i[tsps_pkg::TolW-1:0];
        tsps_pkg::CfgIdleTarget: cfg_q.idle_target       <= signed'(cfg_data_i[tsps_pkg::TempW-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign ptr_inc = ptr_next + 1'b1;
  assign raddr   = (opcode_i == tsps_pkg::OpStart) ? '0 : tsps_pkg::StepAw'(ptr_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        byp_q      <= wr.we && (wr.addr == raddr);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.opcode        <= opcode_i;
      s1_item_q.temperature   <= temperature_i;
      s1_item_q.entry_index   <= entry_index_i;
      s1_item_q.entry_temp    <= entry_temp_i;
      s1_item_q.entry_minutes <= entry_minutes_i;
      byp_data_q              <= wr.data;
    end
    if (s1_fire) begin
      out_q <= result;
    end
  end

  tsps_ram #(
    .Width (tsps_pkg::EntryW),
    .Depth (tsps_pkg::MaxSteps)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (in_fire),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign entry = byp_q ? byp_data_q : ram_rdata;

  tsps_exec u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_fire),
    .item_i     (s1_item_q),
    .entry_i    (entry),
    .cfg_i      (cfg_q),
    .ptr_next_o (ptr_next),
    .wr_o       (wr),
    .result_o   (result)
  );

  assign out_valid_o        = out_valid_q;
  assign running_o          = out_q.running;
  assign paused_flag_o      = out_q.paused_flag;
  assign waiting_for_temp_o = out_q.waiting_for_temp;
  assign cooling_o          = out_q.cooling;
  assign step_number_o      = out_q.step_number;
  assign target_temp_o      = out_q.target_temp;
  assign heater_force_off_o = out_q.heater_force_off;
  assign mixer_auto_o       = out_q.mixer_auto;
  assign mixer_stop_o       = out_q.mixer_stop;
  assign hold_started_o     = out_q.hold_started;
  assign cool_down_done_o   = out_q.cool_down_done;

  `TSPS_ASSERT_IMPLY(a_heater_off_cool, out_valid_o && heater_force_off_o, cooling_o && mixer_auto_o && mixer_stop_o && running_o, "heater off without cool-down entry")
  `TSPS_ASSERT_IMPLY(a_cool_done_stop, out_valid_o && cool_down_done_o, !running_o && !cooling_o && mixer_stop_o && !mixer_auto_o, "cool-down end did not stop run")
  `TSPS_ASSERT_IMPLY(a_hold_start, out_valid_o && hold_started_o, running_o && !waiting_for_temp_o && !cooling_o, "hold started in wrong state")
  `TSPS_ASSERT_IMPLY(a_exec_hold, s1_valid_q && !s1_fire, ##1 s1_valid_q && $stable(s1_item_q), "stalled command lost")

endmodule

// File: dv/profile_status_checker.sv
// ----------------------------------------------------------------------------
// Profile status checker
// Watches the register, command and status channels of the step sequencer.
// Keeps its own copy of the step table, sequencer flags and timers, computes
// the status beat each accepted command should produce and compares every
// returned beat field by field, in order.
// ----------------------------------------------------------------------------
module profile_status_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  tsps_pkg::item_t   cmd_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  tsps_pkg::result_t status_i,
  output int                mismatches_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [tsps_pkg::TempW-1:0] tbl_temp [tsps_pkg::MaxSteps];
  logic [tsps_pkg::MinW-1:0]         tbl_min  [tsps_pkg::MaxSteps];
  tsps_pkg::cfg_t                    regs;
  logic [tsps_pkg::PtrW-1:0]         cur_step;
  logic                              run_q, pause_q, wait_q, cool_q, mix_auto_q;
  logic signed [tsps_pkg::TempW-1:0] tgt_q;
  logic [tsps_pkg::TimeW-1:0]        hold_cnt, hold_len, cool_cnt;
  tsps_pkg::result_t                 pending_status [$];
  int                                beats;

  initial mismatches_o = 0;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches_o++;
  endtask

  task automatic cmp(input string name, input int got, input int want);
    if (got != want)
      report($sformatf("beat %0d %s: got %0d, want %0d", beats, name, got, want));
  endtask

  task automatic enter_or_finish(inout tsps_pkg::result_t r);
    int steps;
    steps = (regs.step_count > tsps_pkg::MaxSteps) ? tsps_pkg::MaxSteps :
            int'(regs.step_count);
    if (int'(cur_step) >= steps) begin
      r.heater_force_off = 1'b1;
      r.mixer_stop = 1'b1;
      tgt_q = regs.idle_target;
      mix_auto_q = 1'b1;
      cool_q = 1'b1;
      cool_cnt = '0;
    end else begin
      tgt_q = tbl_temp[cur_step[tsps_pkg::StepAw-1:0]];
      hold_len = tsps_pkg::TimeW'(32'(tbl_min[cur_step[tsps_pkg::StepAw-1:0]]) *
                                  tsps_pkg::SecPerMin);
      wait_q = 1'b1;
      hold_cnt = '0;
    end
  endtask

  task automatic tick_second(input logic signed [tsps_pkg::TempW-1:0] t,
                             inout tsps_pkg::result_t r);
    int lim;
    if (!run_q) return;
    if (cool_q) begin
      if (cool_cnt != '1) cool_cnt++;
      if (cool_cnt >= regs.cool_down_seconds) begin
        cool_q = 1'b0;
        run_q = 1'b0;
        pause_q = 1'b0;
        mix_auto_q = 1'b0;
        r.mixer_stop = 1'b1;
        r.cool_down_done = 1'b1;
      end
      return;
    end
    if (pause_q) return;
    if (wait_q) begin
      lim = int'($signed(tgt_q)) - int'(regs.reach_tolerance);
      if (int'($signed(t)) >= lim) begin
        wait_q = 1'b0;
        hold_cnt = '0;
        r.hold_started = 1'b1;
      end
    end else begin
      if (hold_cnt != '1) hold_cnt++;
      if (hold_cnt >= hold_len) begin
        cur_step++;
        enter_or_finish(r);
      end
    end
  endtask

  task automatic advance_profile(input tsps_pkg::item_t c, output tsps_pkg::result_t r);
    r = '0;
    case (c.opcode)
      tsps_pkg::OpTick: tick_second(c.temperature, r);
      tsps_pkg::OpLoad: begin
        if (c.entry_index < tsps_pkg::MaxSteps) begin
          tbl_temp[c.entry_index] = c.entry_temp;
          tbl_min[c.entry_index] = c.entry_minutes;
        end
      end
      tsps_pkg::OpStart: begin
        run_q = 1'b1;
        pause_q = 1'b0;
        cool_q = 1'b0;
        wait_q = 1'b0;
        cur_step = '0;
        hold_cnt = '0;
        cool_cnt = '0;
        enter_or_finish(r);
      end
      tsps_pkg::OpPause: if (run_q) pause_q = 1'b1;
      tsps_pkg::OpResume: pause_q = 1'b0;
      default: ;
    endcase
    r.running = run_q;
    r.paused_flag = pause_q;
    r.waiting_for_temp = wait_q;
    r.cooling = cool_q;
    r.step_number = cur_step;
    r.target_temp = tgt_q;
    r.mixer_auto = mix_auto_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tsps_pkg::result_t want;
    if (!rst_ni) begin
      tbl_temp = '{default: '0};
      tbl_min = '{default: '0};
      regs = '{tsps_pkg::StepCountRst, tsps_pkg::CoolDownRst, tsps_pkg::ToleranceRst,
               tsps_pkg::IdleRst};
      cur_step = '0;
      {run_q, pause_q, wait_q, cool_q, mix_auto_q} = '0;
      tgt_q = tsps_pkg::TargetRst;
      hold_cnt = '0;
      hold_len = '0;
      cool_cnt = '0;
      pending_status.delete();
      beats = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_status.size() == 0) begin
          report($sformatf("status beat %0d arrived with nothing pending", beats));
        end else begin
          want = pending_status.pop_front();
          cmp("running", int'(status_i.running), int'(want.running));
          cmp("paused_flag", int'(status_i.paused_flag), int'(want.paused_flag));
          cmp("waiting_for_temp", int'(status_i.waiting_for_temp),
              int'(want.waiting_for_temp));
          cmp("cooling", int'(status_i.cooling), int'(want.cooling));
          cmp("step_number", int'(status_i.step_number), int'(want.step_number));
          cmp("target_temp", int'(status_i.target_temp), int'(want.target_temp));
          cmp("heater_force_off", int'(status_i.heater_force_off),
              int'(want.heater_force_off));
          cmp("mixer_auto", int'(status_i.mixer_auto), int'(want.mixer_auto));
          cmp("mixer_stop", int'(status_i.mixer_stop), int'(want.mixer_stop));
          cmp("hold_started", int'(status_i.hold_started), int'(want.hold_started));
          cmp("cool_down_done", int'(status_i.cool_down_done), int'(want.cool_down_done));
        end
        beats++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (tsps_pkg::cfg_reg_e'(cfg_index_i))
          tsps_pkg::CfgStepCount:  regs.step_count = cfg_data_i[tsps_pkg::PtrW-1:0];
          tsps_pkg::CfgCoolDown:   regs.cool_down_seconds = cfg_data_i[tsps_pkg::TimeW-1:0];
          tsps_pkg::CfgTolerance:  regs.reach_tolerance = cfg_data_i[tsps_pkg::TolW-1:0];
          tsps_pkg::CfgIdleTarget: regs.idle_target = cfg_data_i[tsps_pkg::TempW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        advance_profile(cmd_i, want);
        pending_status.push_back(want);
      end
    end
    pending_o = pending_status.size();
  end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Step sequencer testbench
// Drives register writes and commands (ticks, step loads, start, pause,
// resume, unused opcodes) into the sequencer under random sender and
// receiver stalls, including a long output hold-off, and leaves the
// checking of every status beat to the profile status checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget = 850;
  localparam int TempMax = 2 ** (tsps_pkg::TempW - 1) - 1;
  localparam int TempMin = -(2 ** (tsps_pkg::TempW - 1));
  localparam int MinMax = 2 ** tsps_pkg::MinW - 1;
  localparam logic [tsps_pkg::OpW-1:0] OpSpareLo = 3'd5;
  localparam logic [tsps_pkg::OpW-1:0] OpSpareHi = 3'd7;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid = 1'b0;
  tsps_pkg::cfg_reg_e cfg_index = tsps_pkg::CfgStepCount;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  tsps_pkg::item_t    cmd = '0;
  logic               out_ready = 1'b0;

  logic                              cfg_ready, in_ready, out_valid;
  logic                              running, paused_flag, waiting_for_temp, cooling;
  logic [tsps_pkg::PtrW-1:0]         step_number;
  logic signed [tsps_pkg::TempW-1:0] target_temp;
  logic                              heater_force_off, mixer_auto, mixer_stop;
  logic                              hold_started, cool_down_done;

  int mismatches, pending;
  int snd_gap_pct = 26;
  int rcv_gap_pct = 51;
  int n_cmds = 0, n_ignored = 0, n_settings = 0, hold_off_asked = 0;

  logic signed [tsps_pkg::TempW-1:0] shadow_temp [tsps_pkg::MaxSteps];
  int                                shadow_tol = int'(tsps_pkg::ToleranceRst);
  int                                shadow_span = 1;

  temperature_step_profile_sequencer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .opcode_i           (cmd.opcode),
    .temperature_i      (cmd.temperature),
    .entry_index_i      (cmd.entry_index),
    .entry_temp_i       (cmd.entry_temp),
    .entry_minutes_i    (cmd.entry_minutes),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .running_o          (running),
    .paused_flag_o      (paused_flag),
    .waiting_for_temp_o (waiting_for_temp),
    .cooling_o          (cooling),
    .step_number_o      (step_number),
    .target_temp_o      (target_temp),
    .heater_force_off_o (heater_force_off),
    .mixer_auto_o       (mixer_auto),
    .mixer_stop_o       (mixer_stop),
    .hold_started_o     (hold_started),
    .cool_down_done_o   (cool_down_done)
  );

  profile_status_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .cmd_i        (cmd),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .status_i     ({running, paused_flag, waiting_for_temp, cooling, step_number,
                    target_temp, heater_force_off, mixer_auto, mixer_stop,
                    hold_started, cool_down_done}),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #(200_000);
    $display("Some tests failed");
    $finish;
  end

  initial begin : receiver
    int hold_left, hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_off_asked) begin
        hold_seen = hold_off_asked;
        hold_left = 40;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_gap_pct);
      end
    end
  end

  function automatic tsps_pkg::item_t cmd_of(input logic [tsps_pkg::OpW-1:0] op,
                                             input int t, input int idx,
                                             input int et, input int em);
    tsps_pkg::item_t it;
    it.opcode = op;
    it.temperature = t[tsps_pkg::TempW-1:0];
    it.entry_index = idx[tsps_pkg::IdxW-1:0];
    it.entry_temp = et[tsps_pkg::TempW-1:0];
    it.entry_minutes = em[tsps_pkg::MinW-1:0];
    return it;
  endfunction

  function automatic tsps_pkg::item_t rand_cmd(input logic [tsps_pkg::OpW-1:0] op);
    return cmd_of(op, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic int pick_temp();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5)
      return int'(shadow_temp[tsps_pkg::StepAw'($urandom_range(0, shadow_span - 1))]) -
             shadow_tol + int'($urandom_range(0, 4)) - 2;
    if (k < 7)
      return TempMax - int'($urandom_range(0, 3));
    return $urandom;
  endfunction

  function automatic int pick_minutes();
    int k;
    k = $urandom_range(0, 24);
    if (k == 0) return $urandom_range(0, MinMax);
    if (k < 6) return 1;
    return 0;
  endfunction

  task automatic issue(input tsps_pkg::item_t it);
    if (n_cmds < ItemTarget / 3) begin
      snd_gap_pct = 26;
      rcv_gap_pct = 51;
    end else if (n_cmds < 2 * ItemTarget / 3) begin
      snd_gap_pct = 51;
      rcv_gap_pct = 26;
    end else begin
      snd_gap_pct = 0;
      rcv_gap_pct = 0;
    end
    if ($urandom_range(0, 99) < snd_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < snd_gap_pct);
    end
    in_valid <= 1'b1;
    cmd <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (it.opcode == tsps_pkg::OpLoad) shadow_temp[it.entry_index] = it.entry_temp;
    if (it.opcode > tsps_pkg::OpResume) n_ignored++;
    else n_cmds++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input tsps_pkg::cfg_reg_e idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [tsps_pkg::PtrW-1:0] sc,
                              input logic [tsps_pkg::TimeW-1:0] cds,
                              input logic [tsps_pkg::TolW-1:0] tol,
                              input logic [tsps_pkg::TempW-1:0] idle);
    logic [15:0] junk;
    junk = 16'($urandom);
    put_reg(tsps_pkg::CfgStepCount, {junk[15:tsps_pkg::PtrW], sc});
    put_reg(tsps_pkg::CfgCoolDown, cds);
    put_reg(tsps_pkg::CfgTolerance, {junk[15:tsps_pkg::TolW], tol});
    put_reg(tsps_pkg::CfgIdleTarget, {junk[15:tsps_pkg::TempW], idle});
    cfg_valid <= 1'b0;
    shadow_tol = int'(tol);
    shadow_span = (sc == 0) ? 1 : (sc > tsps_pkg::MaxSteps) ? tsps_pkg::MaxSteps : int'(sc);
    n_settings++;
  endtask

  task automatic random_phase(input int phase);
    logic [tsps_pkg::PtrW-1:0]  sc;
    logic [tsps_pkg::TimeW-1:0] cds;
    tsps_pkg::item_t            it;
    int                         len, pick, sel;
    drain();
    sc = ($urandom_range(0, 3) == 0) ? tsps_pkg::PtrW'($urandom_range(9, 15)) :
                                       tsps_pkg::PtrW'($urandom_range(0, 8));
    sel = $urandom_range(0, 9);
    cds = (sel == 0) ? '0 : (sel == 9) ? '1 : tsps_pkg::TimeW'($urandom_range(1, 8));
    program_regs(sc, cds, tsps_pkg::TolW'($urandom), tsps_pkg::TempW'($urandom));
    repeat ($urandom_range(0, 4)) begin
      it = rand_cmd(tsps_pkg::OpLoad);
      it.entry_minutes = tsps_pkg::MinW'(pick_minutes());
      issue(it);
    end
    issue(rand_cmd(tsps_pkg::OpStart));
    len = $urandom_range(25, 60);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      it = rand_cmd(tsps_pkg::OpTick);
      if (pick < 72) begin
        it.temperature = tsps_pkg::TempW'(pick_temp());
      end else if (pick < 77) begin
        it.opcode = tsps_pkg::OpPause;
      end else if (pick < 83) begin
        it.opcode = tsps_pkg::OpResume;
      end else if (pick < 89) begin
        it.opcode = tsps_pkg::OpLoad;
        it.entry_minutes = tsps_pkg::MinW'(pick_minutes());
      end else if (pick < 92) begin
        it.opcode = tsps_pkg::OpStart;
      end else begin
        it.opcode = tsps_pkg::OpW'($urandom_range(OpSpareLo, OpSpareHi));
      end
      if (i == len / 2 && phase % 5 == 2) hold_off_asked++;
      issue(it);
    end
  endtask

  initial begin : stimulus
    int t, m, phase;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle pause, start with an empty profile, ticks during cool-down, paused or not
    issue(rand_cmd(tsps_pkg::OpPause));
    issue(rand_cmd(tsps_pkg::OpStart));
    issue(cmd_of(tsps_pkg::OpTick, TempMax, 0, 0, 0));
    issue(rand_cmd(tsps_pkg::OpPause));
    issue(cmd_of(tsps_pkg::OpTick, TempMin, 0, 0, 0));
    issue(rand_cmd(tsps_pkg::OpResume));
    issue(rand_cmd(OpSpareLo));
    issue(rand_cmd(OpSpareHi));
    for (int e = 0; e < tsps_pkg::MaxSteps; e++) begin
      t = $urandom;
      m = 0;
      if (e == 0) t = TempMax;
      if (e == 1) begin
        t = TempMin;
        m = MinMax;
      end
      if (e == 2) m = 1;
      issue(cmd_of(tsps_pkg::OpLoad, $urandom, e, t, m));
    end

    // exact reach boundary with zero tolerance, then reload of the current step
    drain();
    program_regs(tsps_pkg::PtrW'(2), '0, '0, TempMin[tsps_pkg::TempW-1:0]);
    issue(rand_cmd(tsps_pkg::OpStart));
    issue(cmd_of(tsps_pkg::OpTick, TempMax - 1, 0, 0, 0));
    issue(cmd_of(tsps_pkg::OpTick, TempMax, 0, 0, 0));
    issue(rand_cmd(tsps_pkg::OpTick));
    issue(cmd_of(tsps_pkg::OpTick, TempMin, 0, 0, 0));
    issue(cmd_of(tsps_pkg::OpLoad, 0, 1, 0, 0));
    issue(rand_cmd(tsps_pkg::OpTick));

    // oversized step count, widest tolerance, longest cool-down
    drain();
    program_regs('1, '1, '1, TempMax[tsps_pkg::TempW-1:0]);
    issue(rand_cmd(tsps_pkg::OpStart));
    issue(cmd_of(tsps_pkg::OpTick, TempMax - 255, 0, 0, 0));

    phase = 0;
    while (n_cmds + n_ignored < ItemTarget) begin
      random_phase(phase);
      phase++;
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d commands and %0d unused opcodes over %0d register settings,",
             n_cmds, n_ignored, n_settings);
    $display("under sender and receiver stall mixes with long output hold-offs");
    if (mismatches == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
